FILE: sv/mnp_pkg.sv
// Package for the Manhattan nearest-point block: sizes, status codes and
// control structures shared by mnp_dist, the top level and the testbench. Depends on nothing.
`timescale 1ns / 1ps

package mnp_pkg;

  // Store geometry and coordinate width.
  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 16;
  localparam int ADDR_BITS  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int DIST_BITS  = COORD_BITS + 1;
  localparam int POINT_BITS = 2 * COORD_BITS;

  // Item kinds carried on the mode field.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ANSWERED = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_STORED   = 2'd2,
    ST_FULL     = 2'd3
  } mnp_status_e;

  // Control tags that travel with each read beat into the distance unit.
  typedef struct packed {
    logic clear;  // start of a new item: forget the running minimum
    logic vld;    // read data from the store is valid this cycle
    logic last;   // this beat carries the final stored point
  } mnp_acc_ctrl_t;

endpackage

FILE: sv/mnp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
`timescale 1ns / 1ps

module mnp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/mnp_dist.sv
// Distance unit: forms |dx| + |dy| for each point read from the store and
// keeps the running minimum over one query. Depends on mnp_pkg.
`timescale 1ns / 1ps

module mnp_dist
  import mnp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mnp_acc_ctrl_t         ctrl_i,
  input  logic [COORD_BITS-1:0] qx_i,
  input  logic [COORD_BITS-1:0] qy_i,
  input  logic [POINT_BITS-1:0] point_i,
  output logic                  last_o,
  output logic [DIST_BITS-1:0]  best_o
);

  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [DIST_BITS-1:0]  d_d, d_q;
  logic                  dvld_q, dlast_q;
  logic [DIST_BITS-1:0]  best_d, best_q;
  logic                  found_q;
  logic                  take_new;

  // Store entries hold x in the upper half and y in the lower half.
  assign px = point_i[POINT_BITS-1:COORD_BITS];
  assign py = point_i[COORD_BITS-1:0];

  // First stage: absolute differences and their sum.
  always_comb begin
    adx = (qx_i >= px) ? (qx_i - px) : (px - qx_i);
    ady = (qy_i >= py) ? (qy_i - py) : (py - qy_i);
    d_d = {1'b0, adx} + {1'b0, ady};
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q  <= 1'b0;
      dlast_q <= 1'b0;
    end else begin
      dvld_q  <= ctrl_i.vld;
      dlast_q <= ctrl_i.vld & ctrl_i.last;
    end
  end

  // Second stage: compare against the running minimum.
  assign take_new = !found_q || (d_q < best_q);
  assign best_d   = take_new ? d_q : best_q;

  always_ff @(posedge clk_i) begin
    if (dvld_q) begin
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (dvld_q) begin
      found_q <= 1'b1;
    end
  end

  // The minimum including the final point is offered on the last beat.
  assign last_o = dlast_q;
  assign best_o = best_d;

endmodule

FILE: sv/manhattan_nearest_point.sv
// Top level of the Manhattan nearest-point block: command port, point store
// sequencer and result register. Depends on mnp_pkg, mnp_ram and mnp_dist.
`timescale 1ns / 1ps

// Usage:
// An item is taken at a rising edge where start_i is high and busy_o is low.
// mode_i selects an insert or a query; x_coord_i and y_coord_i give the point.
// Every item yields exactly one result beat: done_o is high for one cycle
// with distance_o and status_o valid in that cycle. The receiver cannot stall.
// An insert writes the point into the store memory at the fill count and
// answers in the cycle after it is taken; busy_o stays low, so inserts may
// arrive back to back. An insert into a full store is dropped and reported.
// A query on an empty store answers in the next cycle with the empty status.
// Otherwise a query reads the store one entry per cycle through the memory's
// single read port and holds busy_o high through the scan and the drain that
// follows it, until its answer is given.
// The store is never written while a scan runs, so reads need no forwarding.
// Reset empties the store by clearing the fill count; memory contents are
// left as they are and are never read before being written.

module manhattan_nearest_point
  import mnp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  mode_i,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  output logic                  done_o,
  output logic [DIST_BITS-1:0]  distance_o,
  output logic [1:0]            status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e                state_q;
  logic [CNT_BITS-1:0]   count_q;
  logic [ADDR_BITS-1:0]  raddr_q;
  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic                  rvld_q, rlast_q;
  logic                  done_q;
  logic [DIST_BITS-1:0]  dist_q;
  mnp_status_e           status_q;

  logic                  accept;
  logic                  do_insert;
  logic                  is_full;
  logic                  scan_last;
  logic                  ram_re;
  logic [POINT_BITS-1:0] rdata;
  mnp_acc_ctrl_t         acc_ctrl;
  logic                  acc_last;
  logic [DIST_BITS-1:0]  acc_best;

  // Handshake and item decode.
  assign accept    = start_i && (state_q == S_IDLE);
  assign is_full   = (count_q == CNT_BITS'(MAX_POINTS));
  assign do_insert = accept && (mode_i == MODE_INSERT) && !is_full;
  assign scan_last = ({1'b0, raddr_q} == CNT_BITS'(count_q - 1'b1));
  assign ram_re    = (state_q == S_SCAN);

  // Point store.
  mnp_ram #(
    .WIDTH (POINT_BITS),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_insert),
    .waddr_i (count_q[ADDR_BITS-1:0]),
    .wdata_i ({x_coord_i, y_coord_i}),
    .re_i    (ram_re),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  // Distance and running minimum.
  assign acc_ctrl.clear = accept;
  assign acc_ctrl.vld   = rvld_q;
  assign acc_ctrl.last  = rlast_q;

  mnp_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .point_i (rdata),
    .last_o  (acc_last),
    .best_o  (acc_best)
  );

  // Query point capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= x_coord_i;
      qy_q <= y_coord_i;
    end
  end

  // Sequencer: state, fill count, read address and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      raddr_q  <= '0;
      rvld_q   <= 1'b0;
      rlast_q  <= 1'b0;
      done_q   <= 1'b0;
      dist_q   <= '0;
      status_q <= ST_ANSWERED;
    end else begin
      done_q  <= 1'b0;
      rvld_q  <= ram_re;
      rlast_q <= ram_re && scan_last;
      case (state_q)
        S_IDLE: begin
          raddr_q <= '0;
          if (accept) begin
            if (mode_i == MODE_INSERT) begin
              done_q <= 1'b1;
              dist_q <= '0;
              if (is_full) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_STORED;
                count_q  <= count_q + 1'b1;
              end
            end else if (count_q == '0) begin
              done_q   <= 1'b1;
              dist_q   <= '0;
              status_q <= ST_EMPTY;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state_q <= S_DRAIN;
          end else begin
            raddr_q <= raddr_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (acc_last) begin
            done_q   <= 1'b1;
            dist_q   <= acc_best;
            status_q <= ST_ANSWERED;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign distance_o = dist_q;
  assign status_o   = status_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for manhattan_nearest_point: directed and random insert and
// query beats, checked against a shadow point store. Depends on mnp_pkg and the block.
`timescale 1ns / 1ps

module tb;
  import mnp_pkg::*;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    mnp_status_e          status;
  } answer_t;

  // One row of the directed table; known answers are typed in where obvious.
  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  fixed;
    logic [DIST_BITS-1:0]  distance;
    mnp_status_e           status;
  } dir_row_t;

  localparam int NUM_DIR  = 21;
  localparam int NUM_RAND = 112;
  localparam logic FIX  = 1'b1;
  localparam logic CALC = 1'b0;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0]  DIST_HALF = {1'b0, {COORD_BITS{1'b1}}};
  localparam logic [DIST_BITS-1:0]  DIST_FAR  = {{COORD_BITS{1'b1}}, 1'b0};

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  start_i   = 1'b0;
  logic                  mode_i    = MODE_INSERT;
  logic [COORD_BITS-1:0] x_coord_i = '0;
  logic [COORD_BITS-1:0] y_coord_i = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [DIST_BITS-1:0]  distance_o;
  logic [1:0]            status_o;

  // Shadow copy of the point store and its fill count.
  logic [COORD_BITS-1:0] shadow_x [MAX_POINTS];
  logic [COORD_BITS-1:0] shadow_y [MAX_POINTS];
  int                    shadow_count = 0;

  answer_t  awaited [$];
  answer_t  head_answer;
  dir_row_t dir_rows [NUM_DIR];
  int       n_errors = 0;
  int       n_inserts = 0;
  int       n_queries = 0;
  int       status_seen [4] = '{0, 0, 0, 0};
  logic     idle_on = 1'b1;

  manhattan_nearest_point uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .mode_i     (mode_i),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .done_o     (done_o),
    .distance_o (distance_o),
    .status_o   (status_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Works out the answer to one accepted beat and updates the shadow store.
  function automatic answer_t predict_nearest(input logic mode,
                                              input logic [COORD_BITS-1:0] x,
                                              input logic [COORD_BITS-1:0] y);
    answer_t a;
    int      best;
    int      d;
    int      dx;
    int      dy;
    int      i;
    a.distance = '0;
    a.status   = ST_ANSWERED;
    if (mode == MODE_INSERT) begin
      if (shadow_count < MAX_POINTS) begin
        shadow_x[shadow_count] = x;
        shadow_y[shadow_count] = y;
        shadow_count++;
        a.status = ST_STORED;
      end else begin
        a.status = ST_FULL;
      end
    end else if (shadow_count == 0) begin
      a.status = ST_EMPTY;
    end else begin
      best = 1 << 30;
      for (i = 0; i < shadow_count; i++) begin
        dx = (x >= shadow_x[i]) ? x - shadow_x[i] : shadow_x[i] - x;
        dy = (y >= shadow_y[i]) ? y - shadow_y[i] : shadow_y[i] - y;
        d  = dx + dy;
        if (d < best) begin
          best = d;
        end
      end
      a.distance = best[DIST_BITS-1:0];
    end
    return a;
  endfunction

  // Chooses a point: a corner now and then, often close to a stored point,
  // otherwise anywhere in the plane.
  function automatic void pick_point(output logic [COORD_BITS-1:0] x,
                                     output logic [COORD_BITS-1:0] y);
    int sel;
    int k;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      x = $urandom_range(0, 1) ? COORD_MAX : '0;
      y = $urandom_range(0, 1) ? COORD_MAX : '0;
    end else if (sel <= 3 && shadow_count > 0) begin
      k = $urandom_range(0, shadow_count - 1);
      x = shadow_x[k] ^ COORD_BITS'($urandom_range(0, 3));
      y = shadow_y[k] ^ COORD_BITS'($urandom_range(0, 3));
    end else begin
      x = COORD_BITS'($urandom());
      y = COORD_BITS'($urandom());
    end
  endfunction

  // Presents one beat and waits until the block takes it; the expected
  // answer is queued at the edge of acceptance.
  task automatic put_point(input logic mode, input logic [COORD_BITS-1:0] x,
                           input logic [COORD_BITS-1:0] y, input logic use_fixed,
                           input answer_t fixed);
    answer_t guess;
    start_i   <= 1'b1;
    mode_i    <= mode;
    x_coord_i <= x;
    y_coord_i <= y;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    guess = predict_nearest(mode, x, y);
    awaited.push_back(use_fixed ? fixed : guess);
    if (mode == MODE_INSERT) begin
      n_inserts++;
    end else begin
      n_queries++;
    end
  endtask

  // Leaves the command port idle for as many cycles as the argument asks.
  task automatic hold_off(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops sending until every awaited answer has arrived.
  task automatic drain_answers();
    start_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: every done beat must match the oldest awaited answer.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      status_seen[status_o]++;
      if (awaited.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("ERROR: result with nothing awaited: distance=%0d status=%0d",
                   distance_o, status_o);
        end
      end else begin
        head_answer = awaited.pop_front();
        if (distance_o !== head_answer.distance || status_o !== head_answer.status) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("ERROR: expected distance=%0d status=%0d, got distance=%0d status=%0d",
                     head_answer.distance, head_answer.status, distance_o, status_o);
          end
        end
      end
    end
  end

  // Stimulus: directed table, random mix, then a closing burst of corner queries and a short mix.
  initial begin
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    int                    n;
    dir_rows = '{
      '{MODE_QUERY,  '0,        '0,        FIX,  '0,        ST_EMPTY},
      '{MODE_QUERY,  COORD_MAX, COORD_MAX, FIX,  '0,        ST_EMPTY},
      '{MODE_INSERT, '0,        '0,        FIX,  '0,        ST_STORED},
      '{MODE_QUERY,  '0,        '0,        FIX,  '0,        ST_ANSWERED},
      '{MODE_QUERY,  COORD_MAX, COORD_MAX, FIX,  DIST_FAR,  ST_ANSWERED},
      '{MODE_QUERY,  COORD_MAX, '0,        FIX,  DIST_HALF, ST_ANSWERED},
      '{MODE_INSERT, COORD_MAX, COORD_MAX, FIX,  '0,        ST_STORED},
      '{MODE_QUERY,  COORD_MAX, COORD_MAX, FIX,  '0,        ST_ANSWERED},
      '{MODE_QUERY,  16'h8000,  16'h8000,  CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  '0,        COORD_MAX, CALC, '0,        ST_ANSWERED},
      '{MODE_INSERT, 16'h5555,  16'hAAAA,  FIX,  '0,        ST_STORED},
      '{MODE_INSERT, 16'hAAAA,  16'h5555,  CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  16'h5555,  16'hAAAA,  CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  16'hAAAA,  16'hAAAA,  CALC, '0,        ST_ANSWERED},
      '{MODE_INSERT, '0,        '0,        CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  16'h0001,  '0,        CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  '0,        16'h0001,  CALC, '0,        ST_ANSWERED},
      '{MODE_INSERT, 16'h1234,  16'h0FED,  CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  16'h1235,  16'h0FEC,  CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  16'h7FFF,  16'h8000,  CALC, '0,        ST_ANSWERED},
      '{MODE_QUERY,  16'hFFFE,  16'h0001,  CALC, '0,        ST_ANSWERED}
    };

    // Hold reset, then release it on a clock edge.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, with short random gaps.
    for (n = 0; n < NUM_DIR; n++) begin
      put_point(dir_rows[n].mode, dir_rows[n].x, dir_rows[n].y, dir_rows[n].fixed,
                answer_t'({dir_rows[n].distance, dir_rows[n].status}));
      if ($urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 3));
      end
    end

    // Random mix of inserts and queries; gaps come and go in stretches and
    // stop altogether for the closing stretch.
    for (n = 0; n < NUM_RAND; n++) begin
      idle_on = (n < NUM_RAND - 30) && (((n / 20) % 2) == 0);
      pick_point(px, py);
      put_point(($urandom_range(0, 99) < 55) ? MODE_INSERT : MODE_QUERY, px, py, CALC, '0);
      if (n == NUM_RAND / 2) begin
        drain_answers();
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 3));
      end
    end

    // Closing burst: corner queries and a short mix, back to back.
    put_point(MODE_QUERY, '0, '0, CALC, '0);
    put_point(MODE_QUERY, COORD_MAX, COORD_MAX, CALC, '0);
    for (n = 0; n < 6; n++) begin
      pick_point(px, py);
      put_point(n[0] ? MODE_QUERY : MODE_INSERT, px, py, CALC, '0);
    end

    // Wait for the last answers, then let the clock run on quietly.
    drain_answers();
    repeat (10) @(posedge clk_i);
    n_errors += awaited.size();
    $display("Sent %0d inserts and %0d queries; the store ended with %0d points.",
             n_inserts, n_queries, shadow_count);
    $display("Answers seen: answered %0d, empty %0d, stored %0d, dropped full %0d.",
             status_seen[ST_ANSWERED], status_seen[ST_EMPTY], status_seen[ST_STORED],
             status_seen[ST_FULL]);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("Timeout: answers still awaited: %0d", awaited.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
